/* src/ugbi_pkg.sv */
// Shared types, register codes and default sizes for the bilinear grid interpolator.
package ugbi_pkg;

	localparam int MAX_COLUMNS_DEF   = 64;
	localparam int MAX_ROWS_DEF      = 64;
	localparam int FRACTION_BITS_DEF = 16;

	// Depth of the queue between front and back, and of the result queue.
	localparam int MID_DEPTH = 8;
	localparam int RES_DEPTH = 16;

	localparam logic ACTION_LOAD = 1'b0;
	localparam logic ACTION_EVAL = 1'b1;

	typedef enum logic [2:0] {
		REG_X_ORIGIN     = 3'd0,
		REG_Y_ORIGIN     = 3'd1,
		REG_INV_X_STEP   = 3'd2,
		REG_INV_Y_STEP   = 3'd3,
		REG_COLUMNS_USED = 3'd4,
		REG_ROWS_USED    = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic               action;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic [11:0]        load_index;
		logic signed [31:0] load_value;
	} query_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic               out_of_range;
	} result_t;

	typedef struct packed {
		logic signed [31:0] x_origin;
		logic signed [31:0] y_origin;
		logic [31:0]        inv_x_step;
		logic [31:0]        inv_y_step;
		logic [6:0]         columns_used;
		logic [6:0]         rows_used;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		x_origin:     32'sd0,
		y_origin:     32'sd0,
		inv_x_step:   32'd65536,
		inv_y_step:   32'd65536,
		columns_used: 7'd64,
		rows_used:    7'd64
	};

endpackage

/* src/uniform_grid_bilinear_interp.sv */
// Top level of the bilinear interpolator over a uniform row-major grid.
//
// Queries enter through a queue-like port: a beat is taken when push is high and
// full is low. A load beat writes one grid value and gives no result; an evaluate
// beat gives one result. Results leave through a second queue-like port: the
// oldest result is on the result port while empty is low and leaves when pop is
// high. Results come out in the order the evaluate beats went in.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while the block is idle, which the block does not enforce. Indices
// beyond the register list are ignored. The front end takes one beat a cycle while
// full is low, subtracts the origin, multiplies by the reciprocal step and splits
// the product into cell and fraction over three stages. An eight-entry queue
// separates it from the back end, which reads the four neighbours from four copies
// of the grid memory and blends along x then y over seven stages into a
// sixteen-entry result queue; with no stall both sides sustain one beat per cycle.
// When the receiver stops popping, the result queue fills, the back end stops
// draining the middle queue and full rises once that queue is committed.
// Reset empties both queues and restores the register defaults; the grid memory
// is not cleared, and each entry must be loaded before a query reads it.
module uniform_grid_bilinear_interp import ugbi_pkg::*; #(
	parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS      = MAX_ROWS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	input  query_t      query,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output result_t     result
);

	localparam int AW    = $clog2(MAX_COLUMNS * MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLUMNS + 1);
	localparam int FW    = FRACTION_BITS + 1;
	localparam int MID_W = 2 + AW + CW + 2 * FW + 1 + 32;
	localparam int MCW   = $clog2(MID_DEPTH + 1);
	localparam int OCW   = $clog2(RES_DEPTH + 1);

	cfg_t             cfg_q;
	logic             mid_push, mid_pop, mid_empty;
	logic [MID_W-1:0] mid_wdata, mid_rdata;
	logic [MCW-1:0]   mid_count;
	logic             out_push, out_pop;
	result_t          out_wdata;
	logic [OCW-1:0]   out_count;

	// Register file; the user must write it only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_X_ORIGIN:     cfg_q.x_origin     <= $signed(cfg_data);
				REG_Y_ORIGIN:     cfg_q.y_origin     <= $signed(cfg_data);
				REG_INV_X_STEP:   cfg_q.inv_x_step   <= cfg_data;
				REG_INV_Y_STEP:   cfg_q.inv_y_step   <= cfg_data;
				REG_COLUMNS_USED: cfg_q.columns_used <= cfg_data[6:0];
				REG_ROWS_USED:    cfg_q.rows_used    <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	ugbi_front #(
		.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS),
		.FRACTION_BITS(FRACTION_BITS), .MID_W(MID_W)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.push(push), .query(query), .full(full),
		.mid_count(mid_count), .mid_push(mid_push), .mid_data(mid_wdata)
	);

	ugbi_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_fifo (
		.clk(clk), .arst_n(arst_n), .push(mid_push), .wdata(mid_wdata),
		.pop(mid_pop), .rdata(mid_rdata), .empty(mid_empty), .count(mid_count)
	);

	ugbi_back #(
		.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS),
		.FRACTION_BITS(FRACTION_BITS), .MID_W(MID_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .mid_empty(mid_empty), .mid_data(mid_rdata),
		.mid_pop(mid_pop), .out_count(out_count), .out_push(out_push),
		.out_data(out_wdata)
	);

	assign out_pop = pop && !empty;

	ugbi_fifo #(.WIDTH($bits(result_t)), .DEPTH(RES_DEPTH)) u_res_fifo (
		.clk(clk), .arst_n(arst_n), .push(out_push), .wdata(out_wdata),
		.pop(out_pop), .rdata(result), .empty(empty), .count(out_count)
	);

`ifndef SYNTHESIS
	a_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> (32'(mid_count) < 32'(MID_DEPTH)))
		else $error("middle queue written while full");

	a_mid_pop: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("middle queue read while empty");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (32'(out_count) < 32'(RES_DEPTH)))
		else $error("result queue written while full");

	a_res_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_pop && !out_push) |=> (out_count == $past(out_count) - OCW'(1)))
		else $error("result queue count did not fall on a pop");
`endif

endmodule

/* src/ugbi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ugbi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/ugbi_fifo.sv */
// Small synchronous queue with a fill count; the head is shown combinationally.
module ugbi_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

/* src/ugbi_front.sv */
// Front end: accepts beats, maps query coordinates onto grid cells and queues the work.
module ugbi_front import ugbi_pkg::*; #(
	parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS      = MAX_ROWS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int MID_W         = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           push,
	input  query_t                         query,
	output logic                           full,
	input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
	output logic                           mid_push,
	output logic [MID_W-1:0]               mid_data
);

	localparam int AW  = $clog2(MAX_COLUMNS * MAX_ROWS);
	localparam int CW  = $clog2(MAX_COLUMNS + 1);
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int CXW = $clog2(MAX_COLUMNS);
	localparam int CYW = $clog2(MAX_ROWS);
	localparam int FW  = FRACTION_BITS + 1;

	// Returns {clamped, cell, fraction} for one axis.
	function automatic logic [FW+32:0] axis_map(input logic neg, input logic [63:0] p,
		input logic [31:0] last);
		logic [31:0]   ip;
		logic [31:0]   lo;
		logic [FW-1:0] one;
		ip  = p[63:32];
		lo  = p[31:0];
		one = FW'(1) << FRACTION_BITS;
		if (neg && (p != 64'd0)) begin
			return {1'b1, 32'd0, FW'(0)};
		end else if ((ip > last) || ((ip == last) && (lo != 32'd0))) begin
			return {1'b1, last - 32'd1, one};
		end else if (ip == last) begin
			return {1'b0, last - 32'd1, one};
		end else begin
			return {1'b0, ip, 1'b0, p[31 -: FRACTION_BITS]};
		end
	endfunction

	logic               v_s1, v_s2, v_s3;
	query_t             q_s1;
	logic               act_s2, act_s3;
	logic [11:0]        idx_s2, idx_s3;
	logic signed [31:0] val_s2, val_s3;
	logic               xneg_s2, yneg_s2, xneg_s3, yneg_s3;
	logic [31:0]        xmag_s2, ymag_s2;
	logic [63:0]        xp_s3, yp_s3;

	logic               accept;
	logic signed [32:0] dx, dy;
	logic [31:0]        cu, ru;
	logic [CW-1:0]      cols;
	logic [RW-1:0]      rows;
	logic [FW+32:0]     xm, ym;
	logic [CXW-1:0]     cx;
	logic [CYW-1:0]     cy;
	logic [AW-1:0]      base;
	logic               wr_ok;

	// Every beat in flight holds a place in the queue, so the pipeline never stalls.
	assign full = (32'(mid_count) + 32'(v_s1) + 32'(v_s2) + 32'(v_s3)) >= 32'(MID_DEPTH);
	assign accept = push && !full;

	assign dx = {q_s1.x_coord[31], q_s1.x_coord} - {cfg.x_origin[31], cfg.x_origin};
	assign dy = {q_s1.y_coord[31], q_s1.y_coord} - {cfg.y_origin[31], cfg.y_origin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_s1 <= query;
		end
		act_s2  <= q_s1.action;
		idx_s2  <= q_s1.load_index;
		val_s2  <= q_s1.load_value;
		xneg_s2 <= dx[32];
		yneg_s2 <= dy[32];
		xmag_s2 <= dx[32] ? 32'(-dx) : dx[31:0];
		ymag_s2 <= dy[32] ? 32'(-dy) : dy[31:0];
		act_s3  <= act_s2;
		idx_s3  <= idx_s2;
		val_s3  <= val_s2;
		xneg_s3 <= xneg_s2;
		yneg_s3 <= yneg_s2;
		xp_s3   <= 64'(xmag_s2) * 64'(cfg.inv_x_step);
		yp_s3   <= 64'(ymag_s2) * 64'(cfg.inv_y_step);
	end

	always_comb begin
		cu = 32'(cfg.columns_used);
		ru = 32'(cfg.rows_used);
		if (cu < 32'd2) begin
			cols = CW'(2);
		end else if (cu > 32'(MAX_COLUMNS)) begin
			cols = CW'(MAX_COLUMNS);
		end else begin
			cols = CW'(cu);
		end
		if (ru < 32'd2) begin
			rows = RW'(2);
		end else if (ru > 32'(MAX_ROWS)) begin
			rows = RW'(MAX_ROWS);
		end else begin
			rows = RW'(ru);
		end
		xm    = axis_map(xneg_s3, xp_s3, 32'(cols) - 32'd1);
		ym    = axis_map(yneg_s3, yp_s3, 32'(rows) - 32'd1);
		cx    = CXW'(xm[FW+31:FW]);
		cy    = CYW'(ym[FW+31:FW]);
		base  = AW'(cx) + AW'(cols) * AW'(cy);
		wr_ok = 32'(idx_s3) < 32'(MAX_COLUMNS * MAX_ROWS);
	end

	assign mid_push = v_s3;
	assign mid_data = {act_s3, wr_ok, (act_s3 == ACTION_EVAL) ? base : AW'(idx_s3), cols,
		xm[FW-1:0], ym[FW-1:0], xm[FW+32] | ym[FW+32], val_s3};

endmodule

/* src/ugbi_back.sv */
// Back end: stores loaded grid values and blends four neighbours for each query.
module ugbi_back import ugbi_pkg::*; #(
	parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS      = MAX_ROWS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int MID_W         = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           mid_empty,
	input  logic [MID_W-1:0]               mid_data,
	output logic                           mid_pop,
	input  logic [$clog2(RES_DEPTH+1)-1:0] out_count,
	output logic                           out_push,
	output result_t                        out_data
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_COLUMNS + 1);
	localparam int FW    = FRACTION_BITS + 1;
	localparam int PW    = 34 + FRACTION_BITS;
	localparam logic signed [PW-1:0] HALF   = PW'(1) <<< (FRACTION_BITS - 1);
	localparam logic signed [PW-1:0] SAT_HI = PW'(32'sh7fffffff);
	localparam logic signed [PW-1:0] SAT_LO = PW'($signed(32'h80000000));

	logic               h_eval, h_wr, h_oor;
	logic [AW-1:0]      h_addr;
	logic [CW-1:0]      h_cols;
	logic [FW-1:0]      h_fx, h_fy;
	logic signed [31:0] h_val;

	assign {h_eval, h_wr, h_addr, h_cols, h_fx, h_fy, h_oor, h_val} = mid_data;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [FW-1:0]      fx_s1, fx_s2, fy_s1, fy_s2, fy_s3, fy_s4, fy_s5;
	logic               oor_s1, oor_s2, oor_s3, oor_s4, oor_s5, oor_s6, oor_s7;
	logic [31:0]        q00, q01, q10, q11;
	logic signed [31:0] a0_s2, a1_s2, a0_s3, a1_s3;
	logic signed [32:0] d0_s2, d1_s2;
	logic signed [PW-1:0] p0_s3, p1_s3;
	logic signed [31:0] r0_s4, r1_s4, r0_s5, r0_s6;
	logic signed [32:0] dy_s5;
	logic signed [PW-1:0] py_s6;
	logic signed [31:0] r_s7;

	logic signed [PW-1:0] sum0, sum1, sumy;
	logic               we;

	// Credit check: a result queue place is held for every query still in the stages.
	assign mid_pop = !mid_empty && ((32'(out_count) +
		32'($countones({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7}))) < 32'(RES_DEPTH));
	assign we = mid_pop && (h_eval == ACTION_LOAD) && h_wr;

	// Four copies of the grid let the four neighbours be read in the same cycle.
	ugbi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram00 (
		.clk(clk), .we(we), .waddr(h_addr), .wdata(h_val),
		.raddr(h_addr), .rdata(q00)
	);
	ugbi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram01 (
		.clk(clk), .we(we), .waddr(h_addr), .wdata(h_val),
		.raddr(h_addr + AW'(1)), .rdata(q01)
	);
	ugbi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram10 (
		.clk(clk), .we(we), .waddr(h_addr), .wdata(h_val),
		.raddr(h_addr + AW'(h_cols)), .rdata(q10)
	);
	ugbi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram11 (
		.clk(clk), .we(we), .waddr(h_addr), .wdata(h_val),
		.raddr(h_addr + AW'(h_cols) + AW'(1)), .rdata(q11)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= mid_pop && (h_eval == ACTION_EVAL);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_comb begin
		sum0 = PW'(a0_s3) + ((p0_s3 + HALF) >>> FRACTION_BITS);
		sum1 = PW'(a1_s3) + ((p1_s3 + HALF) >>> FRACTION_BITS);
		sumy = PW'(r0_s6) + ((py_s6 + HALF) >>> FRACTION_BITS);
	end

	always_ff @(posedge clk) begin
		fx_s1  <= h_fx;
		fy_s1  <= h_fy;
		oor_s1 <= h_oor;

		fx_s2  <= fx_s1;
		fy_s2  <= fy_s1;
		oor_s2 <= oor_s1;
		a0_s2  <= $signed(q00);
		a1_s2  <= $signed(q10);
		d0_s2  <= $signed({q01[31], q01}) - $signed({q00[31], q00});
		d1_s2  <= $signed({q11[31], q11}) - $signed({q10[31], q10});

		fy_s3  <= fy_s2;
		oor_s3 <= oor_s2;
		a0_s3  <= a0_s2;
		a1_s3  <= a1_s2;
		p0_s3  <= PW'(d0_s2) * PW'($signed({1'b0, fx_s2}));
		p1_s3  <= PW'(d1_s2) * PW'($signed({1'b0, fx_s2}));

		// A blended value lies between its two inputs, so 32 bits hold it.
		fy_s4  <= fy_s3;
		oor_s4 <= oor_s3;
		r0_s4  <= 32'(sum0);
		r1_s4  <= 32'(sum1);

		fy_s5  <= fy_s4;
		oor_s5 <= oor_s4;
		r0_s5  <= r0_s4;
		dy_s5  <= {r1_s4[31], r1_s4} - {r0_s4[31], r0_s4};

		oor_s6 <= oor_s5;
		r0_s6  <= r0_s5;
		py_s6  <= PW'(dy_s5) * PW'($signed({1'b0, fy_s5}));

		oor_s7 <= oor_s6;
		if (sumy > SAT_HI) begin
			r_s7 <= 32'sh7fffffff;
		end else if (sumy < SAT_LO) begin
			r_s7 <= $signed(32'h80000000);
		end else begin
			r_s7 <= 32'(sumy);
		end
	end

	assign out_push              = v_s7;
	assign out_data.interp_value = r_s7;
	assign out_data.out_of_range = oor_s7;

endmodule

/* tb/uniform_grid_bilinear_interp_tb.sv */
// Self-checking testbench for the uniform grid bilinear interpolator.
module uniform_grid_bilinear_interp_tb;
	import ugbi_pkg::*;

	localparam int       TABLE_DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
	localparam longint   FRAC_ONE    = 64'sd1 << FRACTION_BITS_DEF;
	localparam longint   FRAC_HALF   = 64'sd1 << (FRACTION_BITS_DEF - 1);
	localparam int       CYCLE_LIMIT = 600000;
	// Wait after the last expected result so that the pipeline empties, with margin.
	localparam int       SETTLE      = 30;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        push;
	query_t      query;
	logic        full;
	logic        empty;
	logic        pop;
	result_t     result;

	uniform_grid_bilinear_interp u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.query     (query),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// The testbench's own view of the block: the registers as last written, the
	// grid contents and which entries have been loaded so far.
	cfg_t        grid_cfg;
	logic [31:0] grid_mem [TABLE_DEPTH];
	bit          loaded [TABLE_DEPTH];
	result_t     pending_results [$];

	int          mismatches;
	int          cycles;
	// Number of input beats taken so far, loads included.
	int          beats;
	// When steady is set neither side idles, so that back-to-back stretches occur.
	bit          steady;
	int          pop_gap;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int draw_gap();
		if (steady)
			return 0;
		return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 18));
	endfunction

	function automatic int clamp_size(input logic [6:0] v, input int hi);
		if (v < 2)
			return 2;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	// Maps one coordinate onto the grid axis. Returns 1 when the point was clamped.
	function automatic bit map_axis(input longint coord, input longint origin,
			input longint unsigned inv, input int n, output int cell_no,
			output longint frac);
		longint          d;
		longint unsigned mag;
		longint unsigned p;
		longint unsigned ip;
		longint unsigned last;
		bit              neg;
		d = coord - origin;
		neg = d < 0;
		mag = neg ? -d : d;
		p = mag * inv;
		ip = p >> 32;
		last = longint'(n) - 64'sd1;
		if (neg && p != 0) begin
			cell_no = 0;
			frac = 0;
			return 1'b1;
		end
		if (ip > last || (ip == last && p[31:0] != 0)) begin
			cell_no = int'(last) - 1;
			frac = FRAC_ONE;
			return 1'b1;
		end
		if (ip == last) begin
			cell_no = int'(last) - 1;
			frac = FRAC_ONE;
			return 1'b0;
		end
		cell_no = int'(ip);
		frac = (p >> (32 - FRACTION_BITS_DEF)) & (FRAC_ONE - 1);
		return 1'b0;
	endfunction

	// One linear stage, rounding half up; the arithmetic shift is a floor.
	function automatic longint blend(input longint a, input longint b, input longint f);
		return (a * (FRAC_ONE - f) + b * f + FRAC_HALF) >>> FRACTION_BITS_DEF;
	endfunction

	function automatic longint grid_entry(input int idx);
		return longint'(signed'(grid_mem[idx]));
	endfunction

	// Works out the interpolated value of an evaluate beat, and the index of the
	// lower-left neighbour together with the row pitch so that the caller can
	// make sure all four neighbours have been loaded.
	function automatic result_t interpolate(input query_t q, output int base,
			output int cols);
		int      rows;
		int      cx;
		int      cy;
		longint  fx;
		longint  fy;
		longint  r0;
		longint  r1;
		longint  r;
		bit      clamped;
		result_t res;
		cols = clamp_size(grid_cfg.columns_used, MAX_COLUMNS_DEF);
		rows = clamp_size(grid_cfg.rows_used, MAX_ROWS_DEF);
		clamped = map_axis(longint'(q.x_coord), longint'(grid_cfg.x_origin),
			grid_cfg.inv_x_step, cols, cx, fx);
		clamped |= map_axis(longint'(q.y_coord), longint'(grid_cfg.y_origin),
			grid_cfg.inv_y_step, rows, cy, fy);
		base = cx + cols * cy;
		r0 = blend(grid_entry(base), grid_entry(base + 1), fx);
		r1 = blend(grid_entry(base + cols), grid_entry(base + cols + 1), fx);
		r = blend(r0, r1, fy);
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		res.interp_value = r[31:0];
		res.out_of_range = clamped;
		return res;
	endfunction

	// Sends one beat after a random gap and, once it is taken, updates the grid
	// copy or queues the expected result.
	task automatic send_beat(input query_t q);
		int      gap;
		int      base;
		int      cols;
		gap = draw_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		query <= q;
		@(posedge clk);
		while (full)
			@(posedge clk);
		beats++;
		if (q.action == ACTION_LOAD) begin
			grid_mem[q.load_index] = q.load_value;
			loaded[q.load_index] = 1'b1;
		end else begin
			pending_results.push_back(interpolate(q, base, cols));
		end
	endtask

	task automatic load_entry(input int idx, input logic [31:0] value);
		query_t q;
		q.action     = ACTION_LOAD;
		q.x_coord    = $urandom;
		q.y_coord    = $urandom;
		q.load_index = 12'(idx);
		q.load_value = value;
		send_beat(q);
	endtask

	// Evaluates at (x, y), first loading any neighbour that has never been written
	// so that the block never reads an undefined entry.
	task automatic evaluate_at(input logic [31:0] x, input logic [31:0] y);
		query_t  q;
		result_t unused;
		int      base;
		int      cols;
		int      corner [4];
		q.action     = ACTION_EVAL;
		q.x_coord    = x;
		q.y_coord    = y;
		q.load_index = 12'($urandom);
		q.load_value = $urandom;
		unused = interpolate(q, base, cols);
		corner = '{base, base + 1, base + cols, base + cols + 1};
		foreach (corner[i])
			if (!loaded[corner[i]])
				load_entry(corner[i], $urandom);
		send_beat(q);
	endtask

	// Lowers push, waits until every expected result has arrived and lets the
	// pipeline settle, so that the block is idle.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all six registers back to back; the block must be idle.
	task automatic write_config(input cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= REG_X_ORIGIN;     cfg_data <= c.x_origin;       @(posedge clk);
		cfg_index <= REG_Y_ORIGIN;     cfg_data <= c.y_origin;       @(posedge clk);
		cfg_index <= REG_INV_X_STEP;   cfg_data <= c.inv_x_step;     @(posedge clk);
		cfg_index <= REG_INV_Y_STEP;   cfg_data <= c.inv_y_step;     @(posedge clk);
		cfg_index <= REG_COLUMNS_USED; cfg_data <= {25'd0, c.columns_used}; @(posedge clk);
		cfg_index <= REG_ROWS_USED;    cfg_data <= {25'd0, c.rows_used};    @(posedge clk);
		cfg_we <= 1'b0;
		grid_cfg = c;
	endtask

	// Picks a coordinate that mostly lands on or just around the grid, so that
	// interior cells, edges and clamping are all reached; now and then a value
	// from the whole range.
	function automatic logic [31:0] aim(input logic signed [31:0] origin,
			input logic [31:0] inv, input logic [6:0] n_raw);
		longint g;
		longint c;
		int     n;
		n = clamp_size(n_raw, 64);
		if (inv == 0 || $urandom_range(0, 4) == 0)
			return $urandom;
		g = longint'($urandom_range(0, (n + 1) * 65536)) - 65536;
		c = longint'(origin) + (g * 65536) / longint'(inv);
		if (c > 64'sd2147483647)
			c = 64'sd2147483647;
		if (c < -64'sd2147483648)
			c = -64'sd2147483648;
		return c[31:0];
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		c.x_origin   = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h40000);
		c.y_origin   = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h40000);
		c.inv_x_step = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 32'h80000);
		c.inv_y_step = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 32'h80000);
		c.columns_used = 7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
			: $urandom_range(2, 12));
		c.rows_used    = 7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
			: $urandom_range(2, 12));
		return c;
	endfunction

	// Result side: pop idles for a random number of cycles after each beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap <= 0;
		end else if (pop && !empty) begin
			pop_gap = draw_gap();
			pop <= (pop_gap == 0);
		end else if (!pop) begin
			if (pop_gap > 1)
				pop_gap <= pop_gap - 1;
			else
				pop <= 1'b1;
		end
	end

	// Each result beat is compared with the oldest expected result.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: value %h flag %b",
						result.interp_value, result.out_of_range);
			end else begin
				want = pending_results.pop_front();
				if (result.interp_value !== want.interp_value
						|| result.out_of_range !== want.out_of_range) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %h flag %b, got value %h flag %b",
							want.interp_value, want.out_of_range,
							result.interp_value, result.out_of_range);
				end
			end
		end
	end

	// Reset defaults: exact grid points, fractions, both edges, the exact last
	// point, the full coordinate range and extreme load values and indices.
	task automatic test_directed_defaults();
		load_entry(0, 32'h7FFF_FFFF);
		load_entry(1, 32'h8000_0000);
		load_entry(64, 32'h0000_0000);
		load_entry(65, 32'hFFFF_FFFF);
		load_entry(TABLE_DEPTH - 1, 32'h8000_0000);
		evaluate_at(32'h0000_0000, 32'h0000_0000);
		evaluate_at(32'h0000_8000, 32'h0000_8000);
		evaluate_at(32'h0000_FFFF, 32'h0000_0001);
		evaluate_at(32'h0000_C000, 32'h0000_4000);
		evaluate_at(32'hFFFF_FFFF, 32'h0000_0000);
		evaluate_at(32'h8000_0000, 32'h8000_0000);
		evaluate_at(32'h003F_0000, 32'h003F_0000);
		evaluate_at(32'h003F_0001, 32'h0000_0000);
		evaluate_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		evaluate_at(32'h0010_2345, 32'h0020_ABCD);
		drain();
	endtask

	// Smallest grid with a zero step and the most negative origin, then sizes beyond both
	// ends of their range with the largest step and origin, and last a column count below the range.
	task automatic test_config_extremes();
		cfg_t c;
		c = '{x_origin: 32'sh8000_0000, y_origin: 32'sh8000_0000,
			inv_x_step: 32'd0, inv_y_step: 32'd0, columns_used: 7'd2, rows_used: 7'd2};
		write_config(c);
		repeat (4) evaluate_at($urandom, $urandom);
		load_entry(3, 32'h7FFF_FFFF);
		evaluate_at(32'h8000_0000, 32'h7FFF_FFFF);
		drain();
		c = '{x_origin: 32'sh7FFF_FFFF, y_origin: 32'sh7FFF_FFFF,
			inv_x_step: 32'hFFFF_FFFF, inv_y_step: 32'hFFFF_FFFF,
			columns_used: 7'd127, rows_used: 7'd0};
		write_config(c);
		evaluate_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		evaluate_at(32'h7FFF_FFFE, 32'h7FFF_FFFF);
		evaluate_at(32'h8000_0000, 32'h8000_0000);
		repeat (4) evaluate_at($urandom, $urandom);
		c.columns_used = 7'd1;
		c.rows_used = 7'd64;
		c.inv_x_step = 32'd65536;
		c.inv_y_step = 32'd65536;
		c.x_origin = 32'sd0;
		c.y_origin = 32'sd0;
		drain();
		write_config(c);
		evaluate_at(32'h0001_8000, 32'h003F_0000);
		drain();
	endtask

	// Random phases, each with its own register setting; loads and evaluates are
	// mixed and most points fall on or near the grid.
	task automatic test_random_phases();
		cfg_t c;
		int   phase;
		int   n;
		phase = 0;
		while (beats < 600) begin
			c = random_config();
			write_config(c);
			steady = (phase % 3 == 2);
			n = $urandom_range(30, 90);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0)
					load_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
				else
					evaluate_at(aim(c.x_origin, c.inv_x_step, c.columns_used),
						aim(c.y_origin, c.inv_y_step, c.rows_used));
			end
			steady = 1'b0;
			// The sender holds off here until every expected result has come.
			drain();
			phase++;
		end
		write_config(CFG_RESET);
		repeat (40)
			evaluate_at(aim(32'sd0, 32'd65536, 7'd64), aim(32'sd0, 32'd65536, 7'd64));
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_X_ORIGIN;
		cfg_data  = '0;
		push      = 1'b0;
		query     = '0;
		mismatches = 0;
		cycles    = 0;
		beats     = 0;
		steady    = 1'b0;
		grid_cfg  = CFG_RESET;
		foreach (grid_mem[i]) begin
			grid_mem[i] = '0;
			loaded[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_config_extremes();
		test_random_phases();

		if (pending_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
